>>> rtl/core/mids_pkg.sv
`default_nettype none

package mids_pkg;

	localparam int unsigned XLEN    = 32;
	localparam int unsigned REG_AW  = 5;
	localparam int unsigned REG_NUM = 32;

	localparam logic [REG_AW-1:0] REG_LINK = 5'd31;

	typedef enum logic [2:0] {
		CLS_NOP    = 3'd0,
		CLS_REG    = 3'd1,
		CLS_IMM    = 3'd2,
		CLS_LOAD   = 3'd3,
		CLS_STORE  = 3'd4,
		CLS_BRANCH = 3'd5,
		CLS_JUMP   = 3'd6,
		CLS_UNK    = 3'd7
	} cls_t;

	typedef enum logic [5:0] {
		MN_NOP   = 6'd0,
		MN_ADD   = 6'd1,
		MN_ADDU  = 6'd2,
		MN_AND   = 6'd3,
		MN_JR    = 6'd4,
		MN_NOR   = 6'd5,
		MN_OR    = 6'd6,
		MN_MOVN  = 6'd7,
		MN_MOVZ  = 6'd8,
		MN_SLT   = 6'd9,
		MN_SLTU  = 6'd10,
		MN_SLL   = 6'd11,
		MN_SRL   = 6'd12,
		MN_SUB   = 6'd13,
		MN_SUBU  = 6'd14,
		MN_XOR   = 6'd15,
		MN_BLTZ  = 6'd16,
		MN_J     = 6'd17,
		MN_JAL   = 6'd18,
		MN_LB    = 6'd19,
		MN_LBU   = 6'd20,
		MN_LHU   = 6'd21,
		MN_LUI   = 6'd22,
		MN_LW    = 6'd23,
		MN_ORI   = 6'd24,
		MN_SLTI  = 6'd25,
		MN_SLTIU = 6'd26,
		MN_SB    = 6'd27,
		MN_SH    = 6'd28,
		MN_SW    = 6'd29,
		MN_ADDI  = 6'd30,
		MN_ADDIU = 6'd31,
		MN_ANDI  = 6'd32,
		MN_XORI  = 6'd33,
		MN_BEQ   = 6'd34,
		MN_BNE   = 6'd35,
		MN_BGTZ  = 6'd36,
		MN_BLEZ  = 6'd37,
		MN_ERR   = 6'd38
	} mnem_t;

	// primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_REGIMM  = 6'h01;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_BLEZ    = 6'h06;
	localparam logic [5:0] OP_BGTZ    = 6'h07;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0a;
	localparam logic [5:0] OP_SLTIU   = 6'h0b;
	localparam logic [5:0] OP_ANDI    = 6'h0c;
	localparam logic [5:0] OP_ORI     = 6'h0d;
	localparam logic [5:0] OP_XORI    = 6'h0e;
	localparam logic [5:0] OP_LUI     = 6'h0f;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_LBU     = 6'h24;
	localparam logic [5:0] OP_LHU     = 6'h25;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SH      = 6'h29;
	localparam logic [5:0] OP_SW      = 6'h2b;

	// SPECIAL function codes
	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_MOVZ = 6'h0a;
	localparam logic [5:0] FN_MOVN = 6'h0b;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_XOR  = 6'h26;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLT  = 6'h2a;
	localparam logic [5:0] FN_SLTU = 6'h2b;

	typedef struct packed {
		cls_t              instr_class;
		mnem_t             mnemonic;
		logic [REG_AW-1:0] src_reg;
		logic [REG_AW-1:0] tgt_reg;
		logic [REG_AW-1:0] dst_reg;
		logic [XLEN-1:0]   imm_value;
		logic [XLEN-1:0]   operand_one;
		logic [XLEN-1:0]   operand_two;
		logic [XLEN-1:0]   branch_target;
		logic              redirect;
	} dec_res_t;

endpackage

`default_nettype wire

>>> rtl/core/mids_in_if.sv
`default_nettype none

interface mids_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] instruction;
	logic [31:0] fetch_pc;
	logic [4:0]  write_index;
	logic [31:0] write_value;

	modport source (
		output valid, action, instruction, fetch_pc, write_index, write_value,
		input  ready
	);
	modport sink (
		input  valid, action, instruction, fetch_pc, write_index, write_value,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/core/mids_out_if.sv
`default_nettype none

interface mids_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  instr_class;
	logic [5:0]  mnemonic;
	logic [4:0]  src_reg;
	logic [4:0]  tgt_reg;
	logic [4:0]  dst_reg;
	logic [31:0] imm_value;
	logic [31:0] operand_one;
	logic [31:0] operand_two;
	logic [31:0] branch_target;
	logic        redirect;

	modport source (
		output valid, instr_class, mnemonic, src_reg, tgt_reg, dst_reg, imm_value,
		       operand_one, operand_two, branch_target, redirect,
		input  ready
	);
	modport sink (
		input  valid, instr_class, mnemonic, src_reg, tgt_reg, dst_reg, imm_value,
		       operand_one, operand_two, branch_target, redirect,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/core/mids_ram.sv
`default_nettype none

module mids_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output      logic [WIDTH-1:0] rdata_a,
	output      logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/mids_decoder.sv
`default_nettype none

module mids_decoder (
	input  wire logic [31:0]        instruction,
	input  wire logic [31:0]        rs_val,
	input  wire logic [31:0]        rt_val,
	output      mids_pkg::dec_res_t res
);

	logic [5:0]  op;
	logic [5:0]  fn;
	logic [4:0]  sh;
	logic [31:0] imm_raw;
	logic [31:0] imm_sx;

	assign op      = instruction[31:26];
	assign fn      = instruction[5:0];
	assign sh      = instruction[10:6];
	assign imm_raw = {16'h0000, instruction[15:0]};
	assign imm_sx  = {{16{instruction[15]}}, instruction[15:0]};

	always_comb begin
		res               = '0;
		res.src_reg       = instruction[25:21];
		res.tgt_reg       = instruction[20:16];
		res.dst_reg       = instruction[15:11];
		res.imm_value     = imm_raw;
		res.instr_class   = mids_pkg::CLS_NOP;
		res.mnemonic      = mids_pkg::MN_NOP;

		if (instruction == 32'h0000_0000) begin
			res.tgt_reg   = '0;
			res.dst_reg   = '0;
			res.imm_value = '0;
		end else if (op == mids_pkg::OP_SPECIAL) begin
			res.instr_class = mids_pkg::CLS_REG;
			res.operand_one = rs_val;
			res.operand_two = rt_val;
			unique case (fn)
				mids_pkg::FN_ADD:  res.mnemonic = mids_pkg::MN_ADD;
				mids_pkg::FN_ADDU: res.mnemonic = mids_pkg::MN_ADDU;
				mids_pkg::FN_AND:  res.mnemonic = mids_pkg::MN_AND;
				mids_pkg::FN_JR: begin
					res.mnemonic      = mids_pkg::MN_JR;
					res.instr_class   = mids_pkg::CLS_BRANCH;
					res.operand_two   = '0;
					res.tgt_reg       = '0;
					res.dst_reg       = '0;
					res.branch_target = rs_val;
				end
				mids_pkg::FN_NOR:  res.mnemonic = mids_pkg::MN_NOR;
				mids_pkg::FN_OR:   res.mnemonic = mids_pkg::MN_OR;
				mids_pkg::FN_MOVN: res.mnemonic = mids_pkg::MN_MOVN;
				mids_pkg::FN_MOVZ: res.mnemonic = mids_pkg::MN_MOVZ;
				mids_pkg::FN_SLT:  res.mnemonic = mids_pkg::MN_SLT;
				mids_pkg::FN_SLTU: res.mnemonic = mids_pkg::MN_SLTU;
				mids_pkg::FN_SLL: begin
					res.mnemonic    = mids_pkg::MN_SLL;
					res.operand_one = {27'd0, sh};
				end
				mids_pkg::FN_SRL: begin
					res.mnemonic    = mids_pkg::MN_SRL;
					res.operand_one = {27'd0, sh};
				end
				mids_pkg::FN_SUB:  res.mnemonic = mids_pkg::MN_SUB;
				mids_pkg::FN_SUBU: res.mnemonic = mids_pkg::MN_SUBU;
				mids_pkg::FN_XOR:  res.mnemonic = mids_pkg::MN_XOR;
				default:           res.mnemonic = mids_pkg::MN_ERR;
			endcase
		end else if (op == mids_pkg::OP_REGIMM) begin
			res.instr_class   = mids_pkg::CLS_BRANCH;
			res.mnemonic      = mids_pkg::MN_BLTZ;
			res.operand_one   = rs_val;
			res.tgt_reg       = '0;
			res.imm_value     = imm_sx;
			res.branch_target = imm_sx;
		end else if (op == mids_pkg::OP_J || op == mids_pkg::OP_JAL) begin
			res.instr_class   = mids_pkg::CLS_JUMP;
			res.mnemonic      = (op == mids_pkg::OP_J) ? mids_pkg::MN_J : mids_pkg::MN_JAL;
			res.branch_target = {6'd0, instruction[25:0]};
			res.redirect      = 1'b1;
		end else begin
			res.operand_one = rs_val;
			res.operand_two = rt_val;
			res.imm_value   = imm_sx;
			unique case (op)
				mids_pkg::OP_LB: begin
					res.instr_class = mids_pkg::CLS_LOAD;
					res.mnemonic    = mids_pkg::MN_LB;
				end
				mids_pkg::OP_LBU: begin
					res.instr_class = mids_pkg::CLS_LOAD;
					res.mnemonic    = mids_pkg::MN_LBU;
				end
				mids_pkg::OP_LHU: begin
					res.instr_class = mids_pkg::CLS_LOAD;
					res.mnemonic    = mids_pkg::MN_LHU;
				end
				mids_pkg::OP_LUI: begin
					res.instr_class = mids_pkg::CLS_IMM;
					res.mnemonic    = mids_pkg::MN_LUI;
					res.imm_value   = {instruction[15:0], 16'h0000};
				end
				mids_pkg::OP_LW: begin
					res.instr_class = mids_pkg::CLS_LOAD;
					res.mnemonic    = mids_pkg::MN_LW;
				end
				mids_pkg::OP_ORI: begin
					res.instr_class = mids_pkg::CLS_IMM;
					res.mnemonic    = mids_pkg::MN_ORI;
					res.imm_value   = imm_raw;
				end
				mids_pkg::OP_SLTI: begin
					res.instr_class = mids_pkg::CLS_IMM;
					res.mnemonic    = mids_pkg::MN_SLTI;
				end
				mids_pkg::OP_SLTIU: begin
					res.instr_class = mids_pkg::CLS_IMM;
					res.mnemonic    = mids_pkg::MN_SLTIU;
				end
				mids_pkg::OP_SB: begin
					res.instr_class = mids_pkg::CLS_STORE;
					res.mnemonic    = mids_pkg::MN_SB;
				end
				mids_pkg::OP_SH: begin
					res.instr_class = mids_pkg::CLS_STORE;
					res.mnemonic    = mids_pkg::MN_SH;
				end
				mids_pkg::OP_SW: begin
					res.instr_class = mids_pkg::CLS_STORE;
					res.mnemonic    = mids_pkg::MN_SW;
				end
				mids_pkg::OP_ADDI: begin
					res.instr_class = mids_pkg::CLS_IMM;
					res.mnemonic    = mids_pkg::MN_ADDI;
				end
				mids_pkg::OP_ADDIU: begin
					res.instr_class = mids_pkg::CLS_IMM;
					res.mnemonic    = mids_pkg::MN_ADDIU;
				end
				mids_pkg::OP_ANDI: begin
					res.instr_class = mids_pkg::CLS_IMM;
					res.mnemonic    = mids_pkg::MN_ANDI;
					res.imm_value   = imm_raw;
				end
				mids_pkg::OP_XORI: begin
					res.instr_class = mids_pkg::CLS_IMM;
					res.mnemonic    = mids_pkg::MN_XORI;
					res.imm_value   = imm_raw;
				end
				mids_pkg::OP_BEQ: begin
					res.instr_class   = mids_pkg::CLS_BRANCH;
					res.mnemonic      = mids_pkg::MN_BEQ;
					res.branch_target = imm_sx;
				end
				mids_pkg::OP_BNE: begin
					res.instr_class   = mids_pkg::CLS_BRANCH;
					res.mnemonic      = mids_pkg::MN_BNE;
					res.branch_target = imm_sx;
				end
				mids_pkg::OP_BGTZ: begin
					res.instr_class   = mids_pkg::CLS_BRANCH;
					res.mnemonic      = mids_pkg::MN_BGTZ;
					res.tgt_reg       = '0;
					res.operand_two   = '0;
					res.branch_target = imm_sx;
				end
				mids_pkg::OP_BLEZ: begin
					res.instr_class   = mids_pkg::CLS_BRANCH;
					res.mnemonic      = mids_pkg::MN_BLEZ;
					res.tgt_reg       = '0;
					res.operand_two   = '0;
					res.branch_target = imm_sx;
				end
				default: begin
					// unknown opcode keeps the raw immediate
					res.instr_class = mids_pkg::CLS_UNK;
					res.mnemonic    = mids_pkg::MN_ERR;
					res.imm_value   = imm_raw;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/mips_instruction_decode_stage.sv
// Decode stage with a private 32 x 32 register file.
// dec_in (valid/ready): one beat per item. action 0 decodes instruction and
// produces one beat on dec_out; action 1 writes write_value into register
// write_index and produces nothing. JAL also writes fetch_pc+1 to r31 at its
// accept edge, after its own register reads.
// dec_out (valid/ready): class, mnemonic, register fields, extended
// immediate, both operands, branch target and the redirect flag.
// Path: a decode beat is registered into the s1 stage along with its register
// reads, decoded combinationally, and registered into s2, which drives dec_out.
// Throughput: one beat per cycle while dec_out is not held; the two-port
// register file RAM launches its reads at the accept edge.
// Reset: dec_out goes empty and all 32 registers read as zero (per-register
// valid flags clear at once); no clearing pass, dec_in is ready right away.
// Stall: when dec_out is held, the s2 register keeps its beat, s1 fills
// with one more decode beat, then dec_in.ready drops until dec_out moves.
`default_nettype none

module mips_instruction_decode_stage (
	input wire logic  clk,
	input wire logic  arst_n,
	mids_in_if.sink   dec_in,
	mids_out_if.source dec_out
);

	logic                     acc;
	logic                     dec_acc;
	logic                     wr_acc;
	logic                     jal_acc;
	logic                     s1_adv;

	logic                     rf_we;
	logic [mids_pkg::REG_AW-1:0] rf_waddr;
	logic [mids_pkg::XLEN-1:0]   rf_wdata;
	logic [mids_pkg::XLEN-1:0]   rdata_a;
	logic [mids_pkg::XLEN-1:0]   rdata_b;
	logic [mids_pkg::REG_NUM-1:0] rf_vld_q;

	logic                     vld_s1;
	logic [31:0]              ins_s1;
	logic                     rs_vld_s1;
	logic                     rt_vld_s1;
	logic [mids_pkg::XLEN-1:0] rs_val;
	logic [mids_pkg::XLEN-1:0] rt_val;

	mids_pkg::dec_res_t       dec_res;
	logic                     vld_s2;
	mids_pkg::dec_res_t       res_s2;

	assign s1_adv       = !vld_s2 || dec_out.ready;
	assign dec_in.ready = !vld_s1 || s1_adv;

	assign acc     = dec_in.valid && dec_in.ready;
	assign dec_acc = acc && !dec_in.action;
	assign wr_acc  = acc && dec_in.action;
	assign jal_acc = dec_acc && (dec_in.instruction[31:26] == mids_pkg::OP_JAL);

	assign rf_we    = wr_acc || jal_acc;
	assign rf_waddr = wr_acc ? dec_in.write_index : mids_pkg::REG_LINK;
	assign rf_wdata = wr_acc ? dec_in.write_value : dec_in.fetch_pc + 32'd1;

	mids_ram #(
		.WIDTH (mids_pkg::XLEN),
		.DEPTH (mids_pkg::REG_NUM)
	) u_regfile (
		.clk     (clk),
		.we      (rf_we),
		.waddr   (rf_waddr),
		.wdata   (rf_wdata),
		.re      (dec_acc),
		.raddr_a (dec_in.instruction[25:21]),
		.raddr_b (dec_in.instruction[20:16]),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// a register never written since reset reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (rf_we) begin
			rf_vld_q[rf_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (acc) begin
			vld_s1 <= !dec_in.action;
		end else if (s1_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_acc) begin
			ins_s1    <= dec_in.instruction;
			rs_vld_s1 <= rf_vld_q[dec_in.instruction[25:21]];
			rt_vld_s1 <= rf_vld_q[dec_in.instruction[20:16]];
		end
	end

	assign rs_val = rs_vld_s1 ? rdata_a : '0;
	assign rt_val = rt_vld_s1 ? rdata_b : '0;

	mids_decoder u_decoder (
		.instruction (ins_s1),
		.rs_val      (rs_val),
		.rt_val      (rt_val),
		.res         (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s1_adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && vld_s1) begin
			res_s2 <= dec_res;
		end
	end

	assign dec_out.valid         = vld_s2;
	assign dec_out.instr_class   = res_s2.instr_class;
	assign dec_out.mnemonic      = res_s2.mnemonic;
	assign dec_out.src_reg       = res_s2.src_reg;
	assign dec_out.tgt_reg       = res_s2.tgt_reg;
	assign dec_out.dst_reg       = res_s2.dst_reg;
	assign dec_out.imm_value     = res_s2.imm_value;
	assign dec_out.operand_one   = res_s2.operand_one;
	assign dec_out.operand_two   = res_s2.operand_two;
	assign dec_out.branch_target = res_s2.branch_target;
	assign dec_out.redirect      = res_s2.redirect;

endmodule

`default_nettype wire
